[rtl/tbdlp_pkg.sv]
// ----------------------------------------------------------------------------
// Two-button debounce package
// Word types for the tick and event channels, register indexes and reset
// values shared by the debounce block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbdlp_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned DebW     = 8;
	localparam int unsigned LongW    = 16;

	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_TICKS = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_BUTTONS_ENABLED  = 2'd2;

	localparam logic [DebW-1:0]  DEBOUNCE_TICKS_RST   = 8'd20;
	localparam logic [LongW-1:0] LONG_PRESS_TICKS_RST = 16'd5000;

	typedef struct packed {
		logic next_pin_low;
		logic prev_pin_low;
	} tick_word_t;

	typedef struct packed {
		logic next_event;
		logic prev_event;
		logic both_event;
		logic activity_pulse;
		logic power_off_event;
		logic power_on_event;
		logic soft_off;
	} event_word_t;

endpackage

`default_nettype wire

[rtl/two_button_debounce_long_press_top.sv]
// ----------------------------------------------------------------------------
// Two-button debounce with long-press soft power toggle
// The event word of an accepted tick word is registered and appears in the next cycle.
// Throughput: one tick word per cycle while the output is not stalled; the next-state and event logic sits
// between the counter registers and the output register.
// Reset: counters idle, latches clear, powered on, registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_button_debounce_long_press_top
	import tbdlp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire tick_word_t          in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output event_word_t              out_data
);

	logic [DebW-1:0]  debounce_ticks_q;
	logic [LongW-1:0] long_press_ticks_q;
	logic             buttons_enabled_q;

	logic             last_next_q, last_prev_q;
	logic [DebW-1:0]  next_cnt_q, prev_cnt_q;
	logic [LongW-1:0] long_cnt_q;
	logic             next_latched_q, prev_latched_q, power_off_q;

	logic        out_valid_q;
	event_word_t out_data_q;

	logic accept;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Next-state logic for one tick.
	logic [DebW-1:0]  next_cnt_d, prev_cnt_d, dload;
	logic [LongW-1:0] long_cnt_d, lload;
	logic             next_exp, prev_exp, long_exp, active, active_after;
	logic             next_lat_d, prev_lat_d, power_off_d;
	event_word_t      ev;

	always_comb begin
		next_exp = (next_cnt_q == DebW'(1));
		prev_exp = (prev_cnt_q == DebW'(1));
		long_exp = (long_cnt_q == LongW'(1));
		next_cnt_d = (next_cnt_q != '0) ? next_cnt_q - DebW'(1) : next_cnt_q;
		prev_cnt_d = (prev_cnt_q != '0) ? prev_cnt_q - DebW'(1) : prev_cnt_q;
		long_cnt_d = (long_cnt_q != '0) ? long_cnt_q - LongW'(1) : long_cnt_q;
		dload = (debounce_ticks_q != '0) ? debounce_ticks_q : DebW'(1);
		lload = (long_press_ticks_q != '0) ? long_press_ticks_q : LongW'(1);
		active = buttons_enabled_q & ~power_off_q;
		next_lat_d  = next_latched_q;
		prev_lat_d  = prev_latched_q;
		power_off_d = power_off_q;
		ev = '0;

		if (active && (next_exp || prev_exp)) begin
			ev.activity_pulse = 1'b1;
			if (next_exp) begin
				next_lat_d = in_data.next_pin_low;
			end
			if (prev_exp) begin
				prev_lat_d = in_data.prev_pin_low;
			end
			// A simultaneous latch of both buttons is the restart request only.
			if (next_lat_d && prev_lat_d) begin
				ev.both_event = 1'b1;
				next_lat_d = 1'b0;
				prev_lat_d = 1'b0;
			end else begin
				ev.next_event = next_exp & in_data.next_pin_low;
				ev.prev_event = prev_exp & in_data.prev_pin_low;
			end
		end

		if (long_exp && in_data.prev_pin_low) begin
			power_off_d = ~power_off_q;
			ev.power_off_event = power_off_d;
			ev.power_on_event  = ~power_off_d;
		end

		active_after = buttons_enabled_q & ~power_off_d;
		if (in_data.next_pin_low && !last_next_q) begin
			if (active_after) begin
				next_cnt_d = dload;
			end
		end else if (!in_data.next_pin_low && last_next_q) begin
			next_lat_d = 1'b0;
		end
		if (in_data.prev_pin_low && !last_prev_q) begin
			long_cnt_d = lload;
			if (buttons_enabled_q) begin
				prev_cnt_d = dload;
			end
		end else if (!in_data.prev_pin_low && last_prev_q) begin
			prev_lat_d = 1'b0;
			long_cnt_d = '0;
		end
		ev.soft_off = power_off_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= DEBOUNCE_TICKS_RST;
			long_press_ticks_q <= LONG_PRESS_TICKS_RST;
			buttons_enabled_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE_TICKS:   debounce_ticks_q   <= cfg_data[DebW-1:0];
				CFG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_data[LongW-1:0];
				CFG_BUTTONS_ENABLED:  buttons_enabled_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_next_q    <= 1'b0;
			last_prev_q    <= 1'b0;
			next_cnt_q     <= '0;
			prev_cnt_q     <= '0;
			long_cnt_q     <= '0;
			next_latched_q <= 1'b0;
			prev_latched_q <= 1'b0;
			power_off_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				last_next_q    <= in_data.next_pin_low;
				last_prev_q    <= in_data.prev_pin_low;
				next_cnt_q     <= next_cnt_d;
				prev_cnt_q     <= prev_cnt_d;
				long_cnt_q     <= long_cnt_d;
				next_latched_q <= next_lat_d;
				prev_latched_q <= prev_lat_d;
				power_off_q    <= power_off_d;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= ev;
		end
	end

endmodule

`default_nettype wire
